FILE: rtl/core/sha1bcm_pkg.sv
// shared types and constants for the sha1 block compression core
`default_nettype none

package sha1bcm_pkg;

  localparam int ROUNDS    = 80;
  localparam int ROUND_W   = $clog2(ROUNDS);
  localparam int NUM_CHAIN = 5;
  localparam int CHAIN_W   = $clog2(NUM_CHAIN);
  localparam int NUM_MSG   = 16;
  localparam int MSG_W     = $clog2(NUM_MSG);

  // round phase boundaries
  localparam logic [ROUND_W-1:0] PHASE1_START = ROUND_W'(20);
  localparam logic [ROUND_W-1:0] PHASE2_START = ROUND_W'(40);
  localparam logic [ROUND_W-1:0] PHASE3_START = ROUND_W'(60);
  localparam logic [ROUND_W-1:0] LAST_ROUND   = ROUND_W'(ROUNDS - 1);

  // masked message word positions
  localparam logic [MSG_W-1:0] MASK_POS_A = MSG_W'(6);
  localparam logic [MSG_W-1:0] MASK_POS_B = MSG_W'(14);

  // item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  // configuration register indices
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_K0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_K1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_K2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_K3    = 3'd4;

  localparam logic [31:0] K0_RESET = 32'h5A827999;
  localparam logic [31:0] K1_RESET = 32'h6ED9EBA1;
  localparam logic [31:0] K2_RESET = 32'h8F1BBCDC;
  localparam logic [31:0] K3_RESET = 32'hCA62C1D6;

  localparam logic [CHAIN_W-1:0] LAST_CHAIN = CHAIN_W'(NUM_CHAIN - 1);

  typedef struct packed {
    logic        op;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        block_end;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        final_word;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic               take;       // input transfer this cycle
    logic               start;      // transfer starts a compression
    logic               round;      // run one round
    logic [ROUND_W-1:0] round_idx;
    logic               add;        // fold working vars into chain
    logic [CHAIN_W-1:0] emit_idx;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sha1bcm_ctrl.sv
// controller: sequences input transfers, rounds, chain update and result output
`default_nettype none

module sha1bcm_ctrl
  import sha1bcm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_ready,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]         state, state_next;
  logic [ROUND_W-1:0] round_cnt, round_cnt_next;
  logic [CHAIN_W-1:0] emit_cnt, emit_cnt_next;
  logic               take;
  logic               start;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_EMIT);
  assign take         = item_valid && item_ready;
  assign start        = take && (item.op == OP_MSG) && item.block_end;

  always_comb begin
    state_next     = state;
    round_cnt_next = round_cnt;
    emit_cnt_next  = emit_cnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next     = S_ROUND;
          round_cnt_next = '0;
        end
      end
      S_ROUND: begin
        if (round_cnt == LAST_ROUND) begin
          state_next     = S_ADD;
          round_cnt_next = '0;
        end else begin
          round_cnt_next = round_cnt + ROUND_W'(1);
        end
      end
      S_ADD: begin
        state_next    = S_EMIT;
        emit_cnt_next = '0;
      end
      S_EMIT: begin
        if (result_ready) begin
          if (emit_cnt == LAST_CHAIN) begin
            state_next = S_IDLE;
          end else begin
            emit_cnt_next = emit_cnt + CHAIN_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      round_cnt <= '0;
      emit_cnt  <= '0;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
      emit_cnt  <= emit_cnt_next;
    end
  end

  always_comb begin
    cmd.take      = take;
    cmd.start     = start;
    cmd.round     = (state == S_ROUND);
    cmd.round_idx = round_cnt;
    cmd.add       = (state == S_ADD);
    cmd.emit_idx  = emit_cnt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha1bcm_datapath.sv
// datapath: config registers, chain and message words, schedule window and round logic
`default_nettype none

module sha1bcm_datapath
  import sha1bcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire item_t                item,
  input  wire cmd_t                 cmd,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic        mask_enable;
  logic [31:0] round_k [4];
  logic [31:0] chain [NUM_CHAIN];
  logic [31:0] msg [NUM_MSG];
  logic [31:0] win [NUM_MSG];
  logic [31:0] a, b, c, d, e;

  logic [31:0] f, k, tmp, w_new;
  logic [31:0] win_load [NUM_MSG];
  logic        is_msg, is_load;

  assign cfg_ready = 1'b1;
  assign is_msg    = cmd.take && (item.op == OP_MSG);
  assign is_load   = cmd.take && (item.op == OP_LOAD) && (item.word_index < 4'(NUM_CHAIN));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable <= 1'b0;
      round_k[0]  <= K0_RESET;
      round_k[1]  <= K1_RESET;
      round_k[2]  <= K2_RESET;
      round_k[3]  <= K3_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MASK_ENABLE: mask_enable <= cfg_data[0];
        CFG_ROUND_K0:    round_k[0]  <= cfg_data;
        CFG_ROUND_K1:    round_k[1]  <= cfg_data;
        CFG_ROUND_K2:    round_k[2]  <= cfg_data;
        CFG_ROUND_K3:    round_k[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // window contents at start: stored words with the incoming one bypassed in, masked positions zeroed when enabled
  always_comb begin
    for (int i = 0; i < NUM_MSG; i++) begin
      win_load[i] = (item.word_index == MSG_W'(i)) ? item.word_value : msg[i];
      if (mask_enable && (MSG_W'(i) == MASK_POS_A || MSG_W'(i) == MASK_POS_B)) begin
        win_load[i] = '0;
      end
    end
  end

  // round function and constant by phase
  always_comb begin
    if (cmd.round_idx < PHASE1_START) begin
      f = (b & c) | (~b & d);
      k = round_k[0];
    end else if (cmd.round_idx < PHASE2_START) begin
      f = b ^ c ^ d;
      k = round_k[1];
    end else if (cmd.round_idx < PHASE3_START) begin
      f = (b & c) | (b & d) | (c & d);
      k = round_k[2];
    end else begin
      f = b ^ c ^ d;
      k = round_k[3];
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + win[0] + k;

  // next schedule word from the sliding window
  always_comb begin
    logic [31:0] x;
    x     = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {x[30:0], x[31]};
  end

  // chain and message words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHAIN; i++) chain[i] <= '0;
      for (int i = 0; i < NUM_MSG; i++) msg[i] <= '0;
    end else begin
      if (is_load) begin
        chain[item.word_index[CHAIN_W-1:0]] <= item.word_value;
      end
      if (is_msg) begin
        msg[item.word_index] <= item.word_value;
      end
      if (cmd.add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
      for (int i = 0; i < NUM_MSG; i++) win[i] <= win_load[i];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
      for (int i = 0; i < NUM_MSG - 1; i++) win[i] <= win[i+1];
      win[NUM_MSG-1] <= w_new;
    end
  end

  always_comb begin
    result.digest_word  = (cmd.emit_idx < CHAIN_W'(NUM_CHAIN)) ? chain[cmd.emit_idx] : '0;
    result.digest_index = 3'(cmd.emit_idx);
    result.final_word   = (cmd.emit_idx == LAST_CHAIN);
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha1_block_compress_masked_core.sv
// SHA-1 block compression core: one round per cycle over a shared round datapath.
// A block_end message word is followed by the rounds and then the chain update; the five
// digest words then go out one per cycle while the result side is ready, and the next
// item is not taken until the last of them has gone out.
// Synchronous reset clears control, chain and message words and restores config defaults.
`default_nettype none

module sha1_block_compress_masked_core
  import sha1bcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cmd_t cmd;

  sha1bcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  sha1bcm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/sha1_block_compress_masked_checker.sv
// digest predictor and result checker for the sha1 block compression core
module sha1_block_compress_masked_checker
  import sha1bcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 item_ready,
  input  wire item_t                item,
  input  wire logic                 result_valid,
  input  wire logic                 result_ready,
  input  wire result_t              result,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int unsigned               fail_count,
  output int unsigned               digests_pending
);

  logic        mask_on;
  logic [31:0] round_k [4];
  logic [31:0] chain [NUM_CHAIN];
  logic [31:0] msg [NUM_MSG];
  result_t     digest_q [$];
  int unsigned mismatches = 0;

  initial begin
    fail_count = 0;
    digests_pending = 0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void clear_state();
    mask_on = 1'b0;
    round_k = '{K0_RESET, K1_RESET, K2_RESET, K3_RESET};
    foreach (chain[i]) chain[i] = '0;
    foreach (msg[i]) msg[i] = '0;
    digest_q.delete();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_MASK_ENABLE: mask_on = data[0];
      CFG_ROUND_K0:    round_k[0] = data;
      CFG_ROUND_K1:    round_k[1] = data;
      CFG_ROUND_K2:    round_k[2] = data;
      CFG_ROUND_K3:    round_k[3] = data;
      default: ;
    endcase
  endfunction

  // 80 rounds over the stored words, then fold into the chaining words
  function automatic void compress_block();
    logic [31:0] w [NUM_MSG];
    logic [31:0] a, b, c, d, e, f, k, wt, sum;
    int r;
    for (r = 0; r < NUM_MSG; r++) w[r] = msg[r];
    // masking hits this compression only, stored words are kept
    if (mask_on) begin
      w[MASK_POS_A] = '0;
      w[MASK_POS_B] = '0;
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < ROUNDS; r++) begin
      if (r < NUM_MSG) begin
        wt = w[r];
      end else begin
        wt = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
        w[r % 16] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = round_k[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = round_k[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = round_k[2];
      end else begin
        f = b ^ c ^ d;
        k = round_k[3];
      end
      sum = rotl(a, 5) + f + e + wt + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void absorb_item(input item_t it);
    result_t r;
    if (it.op == OP_LOAD) begin
      // loads above the last chaining word are dropped
      if (it.word_index < NUM_CHAIN) chain[it.word_index] = it.word_value;
    end else begin
      msg[it.word_index] = it.word_value;
      if (it.block_end) begin
        compress_block();
        for (int i = 0; i < NUM_CHAIN; i++) begin
          r.digest_word  = chain[i];
          r.digest_index = 3'(i);
          r.final_word   = (i == LAST_CHAIN);
          digest_q.push_back(r);
        end
      end
    end
  endfunction

  function automatic void check_digest(input result_t got);
    result_t want;
    if (digest_q.size() == 0) begin
      $error("unexpected digest word %h index %0d", got.digest_word, got.digest_index);
      mismatches++;
    end else begin
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
        mismatches++;
      end
      if (got.digest_index !== want.digest_index) begin
        $error("digest_index: expected %0d, got %0d", want.digest_index, got.digest_index);
        mismatches++;
      end
      if (got.final_word !== want.final_word) begin
        $error("final_word: expected %b, got %b", want.final_word, got.final_word);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (result_valid && result_ready) check_digest(result);
      if (item_valid && item_ready) absorb_item(item);
    end
    // registered so the stimulus side reads them without a race
    fail_count <= mismatches;
    digests_pending <= digest_q.size();
  end

endmodule

FILE: tb/sv/sha1_block_compress_masked_core_test.sv
// stimulus and verdict for the sha1 block compression core
module sha1_block_compress_masked_core_test;
  import sha1bcm_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 120;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 45;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int unsigned fails;
  int unsigned outstanding;
  int unsigned counted_items = 0;
  int unsigned cycles = 0;
  int          stall_left = 0;
  int          free_left = 0;

  sha1_block_compress_masked_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sha1_block_compress_masked_checker digest_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fails), .digests_pending(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, a few long ones, some free stretches
  always @(posedge clk) begin
    int r;
    if (free_left > 0) begin
      free_left--;
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        stall_left = $urandom_range(1, 3);
        result_ready <= 1'b0;
      end else if (r < 28) begin
        stall_left = $urandom_range(10, 40);
        result_ready <= 1'b0;
      end else begin
        if (r == 99) free_left = $urandom_range(100, 300);
        result_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // valid stays up after the transfer, callers lower it for gaps
  task automatic send(input logic kind, input logic [3:0] slot, input logic [31:0] value,
                      input logic last);
    item_t it;
    it.op         = kind;
    it.word_index = slot;
    it.word_value = value;
    it.block_end  = last;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (!(kind == OP_LOAD && slot >= NUM_CHAIN)) counted_items++;
  endtask

  task automatic pause_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every digest word is back and the core has settled
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic reconfigure(input int phase);
    logic [31:0] mask_word;
    logic [31:0] k [4];
    mask_word = $urandom();
    foreach (k[i]) k[i] = $urandom();
    case (phase)
      0, 5: begin
        mask_word[0] = 1'b0;
        k = '{K0_RESET, K1_RESET, K2_RESET, K3_RESET};
      end
      1: mask_word[0] = 1'b1;
      2: begin
        mask_word[0] = 1'b0;
        k = '{32'h0, 32'h0, 32'h0, 32'h0};
      end
      3: begin
        mask_word[0] = 1'b1;
        k = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end
      default: ;
    endcase
    wait_drained();
    write_reg(CFG_MASK_ENABLE, mask_word);
    write_reg(CFG_ROUND_K0, k[0]);
    write_reg(CFG_ROUND_K1, k[1]);
    write_reg(CFG_ROUND_K2, k[2]);
    write_reg(CFG_ROUND_K3, k[3]);
    // indices past the last register must change nothing
    if (phase == 5) begin
      for (int i = 0; i < 3; i++) write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'(i), $urandom());
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_block();
    int  order [NUM_MSG];
    int  n;
    int  j;
    int  tmp;
    bit  burst;
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        send(OP_LOAD, 4'(i), rand_word(), 1'b0);
        if (!burst) pause_sender();
      end
    end
    foreach (order[i]) order[i] = i;
    for (int i = NUM_MSG - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n = ($urandom_range(0, 9) < 7) ? NUM_MSG : $urandom_range(1, NUM_MSG - 1);
    for (int i = 0; i < n; i++) begin
      send(OP_MSG, 4'(order[i]), rand_word(), i == n - 1);
      if (!burst) pause_sender();
    end
    if ($urandom_range(0, 5) == 0) wait_drained();
  endtask

  task automatic send_noise();
    logic kind;
    logic last;
    int   n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      kind = 1'($urandom_range(0, 1));
      last = (kind == OP_MSG) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
      send(kind, 4'($urandom_range(0, 15)), rand_word(), last);
      pause_sender();
    end
  endtask

  initial begin
    int unsigned phase_end;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // standard initial chaining value; a load flagged block_end still loads
    send(OP_LOAD, 4'd0, 32'h6745_2301, 1'b0);
    send(OP_LOAD, 4'd1, 32'hEFCD_AB89, 1'b0);
    send(OP_LOAD, 4'd2, 32'h98BA_DCFE, 1'b0);
    send(OP_LOAD, 4'd3, 32'h1032_5476, 1'b0);
    send(OP_LOAD, 4'd4, 32'hC3D2_E1F0, 1'b1);
    // loads past the chaining words are dropped
    send(OP_LOAD, 4'd5, 32'hFFFF_FFFF, 1'b0);
    send(OP_LOAD, 4'd15, 32'hFFFF_FFFF, 1'b1);
    // padded "abc" block, the remaining words are still zero from reset
    send(OP_MSG, 4'd0, 32'h6162_6380, 1'b0);
    send(OP_MSG, 4'd15, 32'h0000_0018, 1'b1);
    send(OP_MSG, 4'd7, 32'hFFFF_FFFF, 1'b0);
    send(OP_MSG, 4'd6, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // masking on with extreme round constants
    write_reg(CFG_MASK_ENABLE, 32'hFFFF_FFFF);
    write_reg(CFG_ROUND_K0, 32'h0000_0000);
    write_reg(CFG_ROUND_K1, 32'hFFFF_FFFF);
    write_reg(CFG_ROUND_K2, 32'h0000_0000);
    write_reg(CFG_ROUND_K3, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'(i), 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send(OP_MSG, 4'd14, 32'hFFFF_FFFF, 1'b1);
    send(OP_LOAD, 4'd0, 32'h0000_0000, 1'b0);
    send(OP_LOAD, 4'd3, 32'hFFFF_FFFF, 1'b0);
    send(OP_MSG, 4'd0, 32'h0000_0000, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      reconfigure(phase);
      phase_end = counted_items + PHASE_ITEMS;
      while (counted_items < phase_end) begin
        if ($urandom_range(0, 9) < 7) send_block();
        else send_noise();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sha1_block_compress_masked_core.f
rtl/core/sha1bcm_pkg.sv
rtl/core/sha1bcm_ctrl.sv
rtl/core/sha1bcm_datapath.sv
rtl/core/sha1_block_compress_masked_core.sv
tb/sv/sha1_block_compress_masked_checker.sv
tb/sv/sha1_block_compress_masked_core_test.sv
